// ----- src/ptt_pkg.sv -----
// package for the periodic task timer table
// holds sizes, entry layout, result and command codes and the sequencer states
// no dependencies
package ptt_pkg;

  localparam int TaskSlots = 64;
  localparam int IdxW      = 6;
  localparam int CntW      = 7;
  localparam int TimeW     = 48;
  localparam int PeriodW   = 32;
  localparam int TagW      = 32;
  localparam int KindW     = 2;

  localparam logic       CmdAdd  = 1'b0;
  localparam logic       CmdPoll = 1'b1;

  localparam logic [KindW-1:0] KindAddOk  = 2'd0;
  localparam logic [KindW-1:0] KindReject = 2'd1;
  localparam logic [KindW-1:0] KindDue    = 2'd2;
  localparam logic [KindW-1:0] KindNone   = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0]   due;
    logic [PeriodW-1:0] period;
    logic [TagW-1:0]    tag;
  } ptt_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } ptt_state_e;

endpackage

// ----- src/ptt_in_if.sv -----
// command channel of the periodic task timer table
// depends on ptt_pkg
interface ptt_in_if;
  import ptt_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [TimeW-1:0]   now_us;
  logic [PeriodW-1:0] interval_us;
  logic [TagW-1:0]    task_tag;

  modport source (output valid, command, now_us, interval_us, task_tag, input ready);
  modport sink   (input valid, command, now_us, interval_us, task_tag, output ready);
endinterface

// ----- src/ptt_out_if.sv -----
// result channel of the periodic task timer table
// depends on ptt_pkg
interface ptt_out_if;
  import ptt_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [IdxW-1:0]  task_index;
  logic [TagW-1:0]  tag_out;
  logic             last;

  modport source (output valid, kind, task_index, tag_out, last, input ready);
  modport sink   (input valid, kind, task_index, tag_out, last, output ready);
endinterface

// ----- src/periodic_task_timer_table.sv -----
// periodic task timer table: slot memory, scan sequencer and result register
// depends on ptt_pkg, ptt_in_if, ptt_out_if
//
// Usage:
//   in_i carries commands. An add stores due time now_us + interval_us, the
//   interval and the tag in the next free slot and answers with one beat:
//   kind add ok with the slot, or kind reject when all slots are taken.
//   A poll scans the filled slots in index order and returns one beat per
//   slot whose due time is at or before now_us, then moves that due time on
//   by one interval. The final beat of a poll has last set; a poll with
//   nothing due returns no beat.
//   An add answers in the cycle after it is taken. A poll reads one
//   slot per cycle from the slot memory while the receiver does not
//   stall; the read-modify-write of each slot overlaps the read of the
//   next. A new add is taken as soon as the receiver takes the last answer.
//   One due beat is held back until the next due slot or the end of the
//   scan decides its last flag.
//   When the receiver stalls, the result register holds its beat and the
//   scan pauses on the due slot it is at; no command is taken meanwhile.
//   Reset empties the table (the fill count goes to zero); slot contents
//   need no clearing since only filled slots are ever read.
module periodic_task_timer_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptt_in_if.sink        in_i,
  ptt_out_if.source     out_o
);
  import ptt_pkg::*;

  ptt_state_e         state_q, state_d;
  logic [CntW-1:0]    used_q, used_d;
  logic [CntW-1:0]    scan_q, scan_d;
  logic [TimeW-1:0]   now_q, now_d;
  logic               ev_vld_q, ev_vld_d;
  logic [IdxW-1:0]    ev_idx_q, ev_idx_d;
  ptt_entry_t         rd_q;
  logic               pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]    pend_idx_q, pend_idx_d;
  logic [TagW-1:0]    pend_tag_q, pend_tag_d;
  logic               out_vld_q, out_vld_d;
  logic [KindW-1:0]   out_kind_q, out_kind_d;
  logic [IdxW-1:0]    out_idx_q, out_idx_d;
  logic [TagW-1:0]    out_tag_q, out_tag_d;
  logic               out_last_q, out_last_d;

  ptt_entry_t         mem_q [TaskSlots];
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  ptt_entry_t         mem_wdata;
  logic               rd_en;

  logic               in_ready;
  logic               in_fire;
  logic               out_free;
  logic               ev_due;
  logic               stall;
  logic               scan_more;

  assign in_fire   = in_i.valid && in_ready;
  assign out_free  = !out_vld_q || out_o.ready;
  assign ev_due    = ev_vld_q && (rd_q.due <= now_q);
  assign stall     = ev_due && pend_vld_q && !out_free;
  assign scan_more = scan_q < used_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_i.command == CmdPoll) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (!scan_more && !ev_vld_q) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_vld_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    case (state_q)
      S_IDLE:  in_ready = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    used_d     = used_q;
    scan_d     = scan_q;
    now_d      = now_q;
    ev_vld_d   = ev_vld_q;
    ev_idx_d   = ev_idx_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    pend_tag_d = pend_tag_q;
    out_vld_d  = out_vld_q;
    out_kind_d = out_kind_q;
    out_idx_d  = out_idx_q;
    out_tag_d  = out_tag_q;
    out_last_d = out_last_q;
    mem_we     = 1'b0;
    mem_waddr  = ev_idx_q;
    mem_wdata  = rd_q;
    rd_en      = 1'b0;

    if (out_vld_q && out_o.ready) out_vld_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.command == CmdAdd) begin
            out_vld_d  = 1'b1;
            out_last_d = 1'b1;
            out_tag_d  = '0;
            if (used_q < CntW'(TaskSlots)) begin
              mem_we           = 1'b1;
              mem_waddr        = used_q[IdxW-1:0];
              mem_wdata.due    = in_i.now_us + {{(TimeW-PeriodW){1'b0}}, in_i.interval_us};
              mem_wdata.period = in_i.interval_us;
              mem_wdata.tag    = in_i.task_tag;
              out_kind_d       = KindAddOk;
              out_idx_d        = used_q[IdxW-1:0];
              used_d           = used_q + CntW'(1);
            end else begin
              out_kind_d = KindReject;
              out_idx_d  = '0;
            end
          end else begin
            now_d  = in_i.now_us;
            scan_d = '0;
          end
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (ev_due) begin
            mem_we        = 1'b1;
            mem_waddr     = ev_idx_q;
            mem_wdata.due = rd_q.due + {{(TimeW-PeriodW){1'b0}}, rd_q.period};
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_kind_d = KindDue;
              out_idx_d  = pend_idx_q;
              out_tag_d  = pend_tag_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = ev_idx_q;
            pend_tag_d = rd_q.tag;
          end
          if (scan_more) begin
            rd_en    = 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = scan_q[IdxW-1:0];
            scan_d   = scan_q + CntW'(1);
          end else begin
            ev_vld_d = 1'b0;
          end
        end
      end
      S_FLUSH: begin
        if (pend_vld_q && out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = KindDue;
          out_idx_d  = pend_idx_q;
          out_tag_d  = pend_tag_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      scan_q     <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      scan_q     <= scan_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    ev_idx_q   <= ev_idx_d;
    pend_idx_q <= pend_idx_d;
    pend_tag_q <= pend_tag_d;
    out_kind_q <= out_kind_d;
    out_idx_q  <= out_idx_d;
    out_tag_q  <= out_tag_d;
    out_last_q <= out_last_d;
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rd_en) rd_q <= mem_q[scan_q[IdxW-1:0]];
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.task_index = out_idx_q;
  assign out_o.tag_out    = out_tag_q;
  assign out_o.last       = out_last_q;

endmodule

// ----- src/ptt_checker.sv -----
// port-level checks for the periodic task timer table
// depends on ptt_pkg; bound to periodic_task_timer_table
module ptt_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 in_command_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [ptt_pkg::KindW-1:0] out_kind_i,
  input logic [ptt_pkg::IdxW-1:0]  out_task_index_i,
  input logic [ptt_pkg::TagW-1:0]  out_tag_out_i,
  input logic                 out_last_i
);
  import ptt_pkg::*;

  // stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_task_index_i) && $stable(out_tag_out_i) && $stable(out_last_i))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_kind_i != KindNone)
    else $error("unknown result kind");

  // an add answers with a single closing beat without tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KindAddOk || out_kind_i == KindReject)
      |-> out_last_i && out_tag_out_i == '0)
    else $error("add beat not last or tag not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KindReject |-> out_task_index_i == '0)
    else $error("reject beat with nonzero slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i == CmdAdd
      |=> out_valid_i && (out_kind_i == KindAddOk || out_kind_i == KindReject))
    else $error("add not answered in the next cycle");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_command_i     (in_i.command),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_task_index_i (out_o.task_index),
  .out_tag_out_i    (out_o.tag_out),
  .out_last_i       (out_o.last)
);

// ----- bench/tb.sv -----
// self-checking bench for periodic_task_timer_table: directed and random command beats
// predicts every result beat in a local copy of the slot table and compares in order
// depends on ptt_pkg, ptt_in_if, ptt_out_if and the rtl top level
`timescale 1ns / 100ps

module tb;
  import ptt_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 300;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  idx;
    logic [TagW-1:0]  tag;
    logic             last;
  } timer_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptt_in_if  cmd_if ();
  ptt_out_if res_if ();

  periodic_task_timer_table u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if.sink),
    .out_o  (res_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the slot table
  logic [TimeW-1:0]   slot_due    [TaskSlots];
  logic [PeriodW-1:0] slot_period [TaskSlots];
  logic [TagW-1:0]    slot_tag    [TaskSlots];
  int unsigned        slots_filled = 0;

  timer_beat_t owed_beats [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        rx_block = 1'b0;
  logic [TimeW-1:0] tb_now = '0;

  function automatic timer_beat_t mk_beat(logic [KindW-1:0] kind, logic [IdxW-1:0] idx,
                                          logic [TagW-1:0] tag, logic last);
    timer_beat_t b;
    b.kind = kind;
    b.idx  = idx;
    b.tag  = tag;
    b.last = last;
    return b;
  endfunction

  // apply one command to the local table and queue the beats it owes
  function automatic void apply_to_table(logic cmd, logic [TimeW-1:0] now,
                                         logic [PeriodW-1:0] ivl, logic [TagW-1:0] tag);
    timer_beat_t held;
    bit          have_held;
    have_held = 1'b0;
    held = '0;
    if (cmd == CmdAdd) begin
      if (slots_filled >= TaskSlots) begin
        owed_beats.push_back(mk_beat(KindReject, '0, '0, 1'b1));
      end else begin
        slot_due[slots_filled]    = now + {{(TimeW-PeriodW){1'b0}}, ivl};
        slot_period[slots_filled] = ivl;
        slot_tag[slots_filled]    = tag;
        owed_beats.push_back(mk_beat(KindAddOk, IdxW'(slots_filled), '0, 1'b1));
        slots_filled++;
      end
    end else begin
      for (int i = 0; i < slots_filled; i++) begin
        if (slot_due[i] <= now) begin
          if (have_held) owed_beats.push_back(held);
          held = mk_beat(KindDue, IdxW'(i), slot_tag[i], 1'b0);
          have_held = 1'b1;
          slot_due[i] = slot_due[i] + {{(TimeW-PeriodW){1'b0}}, slot_period[i]};
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        owed_beats.push_back(held);
      end
    end
  endfunction

  // result checker
  timer_beat_t got_beat, want_beat;
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      got_beat = mk_beat(res_if.kind, res_if.task_index, res_if.tag_out, res_if.last);
      if (owed_beats.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: kind %0d idx %0d tag %h last %0d",
                   got_beat.kind, got_beat.idx, got_beat.tag, got_beat.last);
        mismatches <= mismatches + 1;
      end else begin
        want_beat = owed_beats.pop_front();
        if (got_beat !== want_beat) begin
          if (mismatches < 10)
            $display({"mismatch: exp kind %0d idx %0d tag %h last %0d, ",
                      "got kind %0d idx %0d tag %h last %0d"},
                     want_beat.kind, want_beat.idx, want_beat.tag, want_beat.last,
                     got_beat.kind, got_beat.idx, got_beat.tag, got_beat.last);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (rx_block) res_if.ready <= 1'b0;
    else          res_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("periodic_task_timer_table regression: fail");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [TimeW-1:0] now,
                           input logic [PeriodW-1:0] ivl, input logic [TagW-1:0] tag);
    int gap;
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= cmd;
    cmd_if.now_us      <= now;
    cmd_if.interval_us <= ivl;
    cmd_if.task_tag    <= tag;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    apply_to_table(cmd, now, ivl, tag);
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // mostly a steadily advancing clock with sensible periods, some noise
  task automatic random_beats(input int n);
    logic               cmd;
    logic [TimeW-1:0]   now;
    logic [PeriodW-1:0] ivl;
    int                 r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        tb_now = tb_now + TimeW'($urandom_range(0, 300));
        now = tb_now;
        cmd = ($urandom_range(0, 99) < (slots_filled < TaskSlots ? 45 : 15)) ? CmdAdd : CmdPoll;
        r = $urandom_range(0, 99);
        if (r < 10)      ivl = '0;
        else if (r < 80) ivl = $urandom_range(1, 600);
        else             ivl = $urandom_range(600, 5000);
      end else begin
        cmd = $urandom_range(0, 1) ? CmdPoll : CmdAdd;
        now = TimeW'({$urandom, $urandom});
        ivl = $urandom;
      end
      send_beat(cmd, now, ivl, $urandom);
    end
  endtask

  task automatic test_directed();
    send_beat(CmdPoll, '0, '0, '0);
    send_beat(CmdAdd, 48'd100, 32'd50, '0);
    send_beat(CmdPoll, 48'd100, '0, '0);
    send_beat(CmdAdd, '0, '0, 32'h1234_5678);
    send_beat(CmdAdd, '0, {PeriodW{1'b1}}, {TagW{1'b1}});
    send_beat(CmdAdd, TimeMax - 48'd10, 32'd100, 32'ha5a5_a5a5);
    send_beat(CmdAdd, 48'd1000, 32'd10, 32'h5a5a_5a5a);
    send_beat(CmdPoll, '0, {PeriodW{1'b1}}, {TagW{1'b1}});
    send_beat(CmdPoll, 48'd5000, '0, '0);
    send_beat(CmdPoll, 48'd5000, '0, '0);
    send_beat(CmdPoll, TimeMax, '0, '0);
    send_beat(CmdPoll, TimeMax, '0, '0);
    send_beat(CmdAdd, TimeMax, {PeriodW{1'b1}}, 32'h8000_0001);
    send_beat(CmdPoll, 48'h8000_0000_0000, '0, '0);
    tb_now = 48'd6000;
    drain();
  endtask

  task automatic test_steady();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    random_beats(27);
    drain();
  endtask

  task automatic test_sender_gaps();
    tx_idle_pct = 52;
    rx_stall_pct <= 0;
    random_beats(27);
    drain();
  endtask

  task automatic test_receiver_stalls();
    tx_idle_pct = 0;
    rx_stall_pct <= 52;
    tb_now = TimeMax - 48'd6000;
    random_beats(27);
    drain();
  endtask

  task automatic test_mixed_idle();
    tx_idle_pct = 26;
    rx_stall_pct <= 26;
    random_beats(27);
    drain();
  endtask

  // receiver blocked for a long stretch while commands keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    fork
      begin
        rx_block <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rx_block <= 1'b0;
      end
    join_none
    for (int k = 0; k < 12; k++) begin
      tb_now = tb_now + TimeW'($urandom_range(500, 3000));
      send_beat(($urandom_range(0, 3) == 0) ? CmdAdd : CmdPoll, tb_now,
                $urandom_range(0, 800), $urandom);
    end
    drain();
  endtask

  initial begin
    cmd_if.valid       <= 1'b0;
    cmd_if.command     <= CmdAdd;
    cmd_if.now_us      <= '0;
    cmd_if.interval_us <= '0;
    cmd_if.task_tag    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_steady();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    test_backpressure();

    if (mismatches == 0 && owed_beats.size() == 0) begin
      $display("periodic_task_timer_table regression: pass");
    end else begin
      $display("periodic_task_timer_table regression: fail");
    end
    $finish;
  end

endmodule
